### hw/rtl/kfr_pkg.sv
package kfr_pkg;

  localparam int KEY_W = 24;
  localparam int PAY_W = 32;
  localparam int CAP_W = 4;
  localparam int CNT_W = 4;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;
  localparam logic [APB_AW-1:0] ADDR_CAP = 3'd0;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_REPLACE = 2'd1,
    OP_POP     = 2'd2,
    OP_LOOKUP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_POP_CAP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_APPEND,
    ST_HEAD_RD,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/keyed_fifo_with_replace.sv
// Keyed FIFO: a bounded queue of key/payload items with push, replace-by-key, pop and
// lookup. One command is accepted when start is high and busy is low; busy then stays
// high until the result has been shown. Each command runs on one key comparator and one
// single-read-port storage array; each entry scanned passes a read state and a compare
// state, and each entry moved when a gap is closed passes a read and a write state. A
// lookup scans to the first match or the end; a push scans the same way, then appends; a
// replace scans, closes the gap at a match, then appends; a pop takes the head and closes
// the gap (an empty queue only reports). The result sits on the out_ ports for exactly
// one cycle, marked by out_valid, and cannot be held off: the receiver must take it in
// that cycle.
module keyed_fifo_with_replace #(
  parameter int DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_op,
  input  logic [kfr_pkg::KEY_W-1:0]         in_key,
  input  logic [kfr_pkg::PAY_W-1:0]         in_payload,

  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic                              out_found,
  output logic [kfr_pkg::KEY_W-1:0]         out_key,
  output logic [kfr_pkg::PAY_W-1:0]         out_payload,
  output logic [kfr_pkg::CNT_W-1:0]         out_count,
  output logic                              out_head_valid,
  output logic [kfr_pkg::KEY_W-1:0]         out_head_key,
  output logic [kfr_pkg::PAY_W-1:0]         out_head_payload,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kfr_pkg::APB_AW-1:0]        paddr,
  input  logic [kfr_pkg::APB_DW-1:0]        pwdata,
  output logic [kfr_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (OCC_W > kfr_pkg::CAP_W) ? OCC_W : kfr_pkg::CAP_W;

  logic [kfr_pkg::KEY_W-1:0] mem_key [DEPTH];
  logic [kfr_pkg::PAY_W-1:0] mem_pay [DEPTH];

  kfr_pkg::state_t  state_r, state_nxt;
  kfr_pkg::op_t     op_r, op_nxt;
  kfr_pkg::status_t status_r, status_nxt;
  logic                      found_r, found_nxt;
  logic [kfr_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [kfr_pkg::PAY_W-1:0] pay_r, pay_nxt;
  logic [kfr_pkg::KEY_W-1:0] okey_r, okey_nxt;
  logic [kfr_pkg::PAY_W-1:0] opay_r, opay_nxt;
  logic [OCC_W-1:0]          idx_r, idx_nxt;
  logic [OCC_W-1:0]          occ_r, occ_nxt;
  logic [kfr_pkg::CAP_W-1:0] cap_r;
  logic [kfr_pkg::KEY_W-1:0] rd_key_r;
  logic [kfr_pkg::PAY_W-1:0] rd_pay_r;

  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [kfr_pkg::KEY_W-1:0] wr_key;
  logic [kfr_pkg::PAY_W-1:0] wr_pay;
  logic [IDX_W-1:0]          rd_addr;
  logic [OCC_W-1:0]          idx_inc;
  logic                      full;
  logic                      accept;
  logic                      cfg_wr;

  assign accept  = start && !busy;
  assign idx_inc = idx_r + OCC_W'(1);
  assign full    = (CMP_W'(occ_r) >= CMP_W'(cap_r)) || (occ_r == OCC_W'(DEPTH));

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[kfr_pkg::APB_AW-1] == kfr_pkg::ADDR_CAP[kfr_pkg::APB_AW-1])
                  ? kfr_pkg::APB_DW'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= kfr_pkg::CAP_RESET;
    end else if (cfg_wr &&
                 paddr[kfr_pkg::APB_AW-1] == kfr_pkg::ADDR_CAP[kfr_pkg::APB_AW-1]) begin
      cap_r <= pwdata[kfr_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_pay[wr_addr] <= wr_pay;
    end
    rd_key_r <= mem_key[rd_addr];
    rd_pay_r <= mem_pay[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kfr_pkg::ST_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    key_r    <= key_nxt;
    pay_r    <= pay_nxt;
    okey_r   <= okey_nxt;
    opay_r   <= opay_nxt;
    idx_r    <= idx_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    key_nxt    = key_r;
    pay_nxt    = pay_r;
    okey_nxt   = okey_r;
    opay_nxt   = opay_r;
    idx_nxt    = idx_r;
    occ_nxt    = occ_r;
    wr_en      = 1'b0;
    wr_addr    = idx_r[IDX_W-1:0];
    wr_key     = rd_key_r;
    wr_pay     = rd_pay_r;
    rd_addr    = '0;

    unique case (state_r)
      kfr_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt     = kfr_pkg::op_t'(in_op);
          key_nxt    = in_key;
          pay_nxt    = in_payload;
          status_nxt = kfr_pkg::STAT_OK;
          found_nxt  = 1'b0;
          okey_nxt   = '0;
          opay_nxt   = '0;
          idx_nxt    = '0;
          if (kfr_pkg::op_t'(in_op) == kfr_pkg::OP_POP) begin
            if (occ_r == '0) begin
              status_nxt = kfr_pkg::STAT_EMPTY;
              state_nxt  = kfr_pkg::ST_HEAD_RD;
            end else begin
              state_nxt = kfr_pkg::ST_POP_CAP;
            end
          end else begin
            state_nxt = kfr_pkg::ST_SCAN_RD;
          end
        end
      end
      kfr_pkg::ST_SCAN_RD: begin
        rd_addr = idx_r[IDX_W-1:0];
        if (idx_r == occ_r) begin
          if (op_r == kfr_pkg::OP_LOOKUP) begin
            status_nxt = kfr_pkg::STAT_NOT_FOUND;
            state_nxt  = kfr_pkg::ST_HEAD_RD;
          end else begin
            state_nxt = kfr_pkg::ST_APPEND;
          end
        end else begin
          state_nxt = kfr_pkg::ST_SCAN_CMP;
        end
      end
      kfr_pkg::ST_SCAN_CMP: begin
        if (rd_key_r == key_r) begin
          found_nxt = 1'b1;
          case (op_r)
            kfr_pkg::OP_REPLACE: state_nxt = kfr_pkg::ST_SHIFT_RD;
            kfr_pkg::OP_LOOKUP:  state_nxt = kfr_pkg::ST_HEAD_RD;
            default:             state_nxt = kfr_pkg::ST_APPEND;
          endcase
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = kfr_pkg::ST_SCAN_RD;
        end
      end
      kfr_pkg::ST_POP_CAP: begin
        okey_nxt  = rd_key_r;
        opay_nxt  = rd_pay_r;
        state_nxt = kfr_pkg::ST_SHIFT_RD;
      end
      kfr_pkg::ST_SHIFT_RD: begin
        rd_addr = idx_inc[IDX_W-1:0];
        if (idx_inc < occ_r) begin
          state_nxt = kfr_pkg::ST_SHIFT_WR;
        end else begin
          occ_nxt   = occ_r - OCC_W'(1);
          state_nxt = (op_r == kfr_pkg::OP_POP) ? kfr_pkg::ST_HEAD_RD : kfr_pkg::ST_APPEND;
        end
      end
      kfr_pkg::ST_SHIFT_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = kfr_pkg::ST_SHIFT_RD;
      end
      kfr_pkg::ST_APPEND: begin
        if (full) begin
          status_nxt = kfr_pkg::STAT_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = occ_r[IDX_W-1:0];
          wr_key  = key_r;
          wr_pay  = pay_r;
          occ_nxt = occ_r + OCC_W'(1);
        end
        state_nxt = kfr_pkg::ST_HEAD_RD;
      end
      kfr_pkg::ST_HEAD_RD: begin
        state_nxt = kfr_pkg::ST_DONE;
      end
      kfr_pkg::ST_DONE: begin
        state_nxt = kfr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = kfr_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != kfr_pkg::ST_IDLE);
  assign out_valid        = (state_r == kfr_pkg::ST_DONE);
  assign out_status       = status_r;
  assign out_found        = found_r;
  assign out_key          = okey_r;
  assign out_payload      = opay_r;
  assign out_count        = kfr_pkg::CNT_W'(occ_r);
  assign out_head_valid   = (occ_r != '0);
  assign out_head_key     = (occ_r != '0) ? rd_key_r : '0;
  assign out_head_payload = (occ_r != '0) ? rd_pay_r : '0;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not raise busy");

endmodule
